// File: rtl/core/motor_drive_lifecycle_supervisor_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the motor drive lifecycle supervisor
// ---------------------------------------------------------------------------
`ifndef MOTOR_DRIVE_LIFECYCLE_SUPERVISOR_DEFINES_SVH
`define MOTOR_DRIVE_LIFECYCLE_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define MDLS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mdls: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define MDLS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mdls: next-cycle check failed");

`endif

// File: rtl/core/mdls_pkg.sv
// ---------------------------------------------------------------------------
// mdls_pkg
// Types and constants shared by the lifecycle supervisor modules.
// ---------------------------------------------------------------------------
package mdls_pkg;

   typedef enum logic [1:0] {
      LIFE_IDLE  = 2'd0,
      LIFE_CALIB = 2'd1,
      LIFE_RUN   = 2'd2,
      LIFE_FAULT = 2'd3
   } life_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_CLEAR = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_POLE_PAIRS = 2'd0,
      CSR_DIR_INV    = 2'd1,
      CSR_ELEC_ZERO  = 2'd2,
      CSR_CAL_LIMIT  = 2'd3
   } csr_index_type;

   localparam logic [1:0] CAL_BUSY = 2'd0;
   localparam logic [1:0] CAL_DONE = 2'd1;

   localparam int FAULT_W = 7;
   localparam logic [FAULT_W-1:0] FLT_TIMEOUT = 7'h01;
   localparam logic [FAULT_W-1:0] FLT_CALIB   = 7'h02;
   localparam logic [FAULT_W-1:0] FLT_SAMPLE  = 7'h04;
   localparam logic [FAULT_W-1:0] FLT_ANGLE   = 7'h08;
   localparam logic [FAULT_W-1:0] FLT_MATH    = 7'h10;
   localparam logic [FAULT_W-1:0] FLT_COMMIT  = 7'h20;
   localparam logic [FAULT_W-1:0] FLT_PWM     = 7'h40;

   localparam logic [7:0]  POLE_PAIRS_RST = 8'd7;
   localparam logic [15:0] CAL_LIMIT_RST  = 16'd2000;

   typedef struct packed {
      logic [7:0]  pole_pairs;
      logic        direction_inverted;
      logic [31:0] electrical_zero;
      logic [15:0] calibration_limit;
   } cfg_type;

   typedef struct packed {
      cmd_type     command;
      logic [1:0]  calib_status;
      logic        sample_ok;
      logic        angle_valid;
      logic [31:0] mech_angle;
      logic        core_ok;
      logic        duty_commit_ok;
      logic        pwm_enable_ok;
   } item_type;

   typedef struct packed {
      life_type          life_state;
      logic [FAULT_W-1:0] fault_flags;
      logic              power_on;
   } ctl_type;

   typedef struct packed {
      logic emergency_stop;
      logic calibration_begin;
      logic core_reset;
      logic angle_updated;
   } pulse_type;

endpackage

// File: rtl/core/mdls_step.sv
// ---------------------------------------------------------------------------
// mdls_step
// One control tick: apply the command, then run the step of the new state.
// ---------------------------------------------------------------------------
module mdls_step import mdls_pkg::*; #(
   parameter int TICK_WIDTH = 16
) (
   input  cfg_type                cfg,
   input  item_type               item,
   input  ctl_type                ctl_cur,
   input  logic [TICK_WIDTH-1:0]  ticks_cur,
   input  logic [31:0]            angle_cur,
   output ctl_type                ctl_nxt,
   output logic [TICK_WIDTH-1:0]  ticks_nxt,
   output logic [31:0]            angle_nxt,
   output pulse_type              pulses
);

   localparam int CMP_W = 33;

   life_type           cmd_life;
   logic               cmd_power;
   logic               cmd_clear;
   logic               cmd_estop;
   logic               cmd_begin;
   logic [TICK_WIDTH-1:0] cmd_ticks;
   logic [TICK_WIDTH-1:0] ticks_inc;
   logic               tick_expired;

   logic               fault_hit;
   logic [FAULT_W-1:0] fault_mask;
   logic               to_run;
   logic               core_rst;
   logic               upd;
   life_type           life_nxt;

   logic [39:0]        prod;
   logic [31:0]        elec_raw;
   logic [31:0]        elec_calc;

   // command phase
   always_comb begin
      cmd_life  = ctl_cur.life_state;
      cmd_power = ctl_cur.power_on;
      cmd_clear = 1'b0;
      cmd_estop = 1'b0;
      cmd_begin = 1'b0;
      cmd_ticks = ticks_cur;
      unique case (item.command)
         CMD_START: begin
            if (ctl_cur.life_state == LIFE_IDLE) begin
               cmd_begin = 1'b1;
               cmd_ticks = '0;
               cmd_life  = LIFE_CALIB;
            end
         end
         CMD_STOP: begin
            cmd_estop = 1'b1;
            cmd_power = 1'b0;
            cmd_life  = LIFE_IDLE;
         end
         CMD_CLEAR: begin
            if (ctl_cur.life_state == LIFE_FAULT && !ctl_cur.power_on) begin
               cmd_clear = 1'b1;
               cmd_life  = LIFE_IDLE;
            end
         end
         default: ;
      endcase
   end

   // saturating calibration tick count
   assign ticks_inc    = (&cmd_ticks) ? cmd_ticks : cmd_ticks + 1'b1;
   assign tick_expired = CMP_W'(ticks_inc) >= CMP_W'(cfg.calibration_limit);

   // electrical angle: one 32x8 product, optional negate, offset
   assign prod      = 40'(item.mech_angle) * 40'(cfg.pole_pairs);
   assign elec_raw  = cfg.direction_inverted ? (32'd0 - prod[31:0]) : prod[31:0];
   assign elec_calc = elec_raw + cfg.electrical_zero;

   // state step checks, first failure wins
   always_comb begin
      fault_hit  = 1'b0;
      fault_mask = '0;
      to_run     = 1'b0;
      core_rst   = 1'b0;
      upd        = 1'b0;
      ticks_nxt  = cmd_ticks;
      unique case (cmd_life)
         LIFE_CALIB: begin
            ticks_nxt = ticks_inc;
            case (item.calib_status)
               CAL_BUSY: begin
                  if (tick_expired) begin
                     fault_hit  = 1'b1;
                     fault_mask = FLT_TIMEOUT;
                  end
               end
               CAL_DONE: begin
                  core_rst = 1'b1;
                  if (!item.duty_commit_ok) begin
                     fault_hit  = 1'b1;
                     fault_mask = FLT_COMMIT;
                  end else if (!item.pwm_enable_ok) begin
                     fault_hit  = 1'b1;
                     fault_mask = FLT_PWM;
                  end else begin
                     to_run = 1'b1;
                  end
               end
               default: begin
                  fault_hit  = 1'b1;
                  fault_mask = FLT_CALIB;
               end
            endcase
         end
         LIFE_RUN: begin
            if (!item.sample_ok) begin
               fault_hit  = 1'b1;
               fault_mask = FLT_SAMPLE;
            end else if (!item.angle_valid) begin
               fault_hit  = 1'b1;
               fault_mask = FLT_ANGLE;
            end else begin
               upd = 1'b1;
               if (!item.core_ok) begin
                  fault_hit  = 1'b1;
                  fault_mask = FLT_MATH;
               end else if (!item.duty_commit_ok) begin
                  fault_hit  = 1'b1;
                  fault_mask = FLT_COMMIT;
               end
            end
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      if (fault_hit) begin
         life_nxt = LIFE_FAULT;
      end else if (to_run) begin
         life_nxt = LIFE_RUN;
      end else begin
         life_nxt = cmd_life;
      end
   end

   // outputs
   always_comb begin
      ctl_nxt.life_state  = life_nxt;
      ctl_nxt.fault_flags = (cmd_clear ? '0 : ctl_cur.fault_flags) | fault_mask;
      if (fault_hit) begin
         ctl_nxt.power_on = 1'b0;
      end else if (to_run) begin
         ctl_nxt.power_on = 1'b1;
      end else begin
         ctl_nxt.power_on = cmd_power;
      end
      angle_nxt                = upd ? elec_calc : angle_cur;
      pulses.emergency_stop    = cmd_estop | fault_hit;
      pulses.calibration_begin = cmd_begin;
      pulses.core_reset        = core_rst;
      pulses.angle_updated     = upd;
   end

endmodule

// File: rtl/core/motor_drive_lifecycle_supervisor.sv
// ---------------------------------------------------------------------------
// motor_drive_lifecycle_supervisor
// Per-tick lifecycle control of a motor drive: idle, calibrating, running,
// fault, with sticky fault bits, PWM enable and electrical angle.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel req_*: one word per control tick carrying the command and
//    the status flags of the sampling, calibration, core and PWM stages.
//  - Result channel rsp_*: one word per input word, in order, carrying state
//    after the tick, sticky faults, PWM flag, pulses and electrical angle.
//  - csr_*: write-only register port (pole pairs, direction, zero offset,
//    calibration limit); write only while no word is in flight.
//  - Path: a word sits in the input register, then the tick logic (one 32x8
//    multiply, add and flag checks) loads the result register and the
//    lifecycle state together.
//  - Throughput: one word per cycle while rsp_ready stays high.
//  - Stall: with rsp_ready low the result word holds; one more word parks in
//    the input register, then req_ready drops until the result drains.
//  - Reset: state idle, faults clear, PWM off, angle zero, registers to their
//    defaults (pole pairs 7, limit 2000); both pipeline stages empty.
// ---------------------------------------------------------------------------
module motor_drive_lifecycle_supervisor import mdls_pkg::*; #(
   parameter int TICK_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [1:0]  req_calib_status,
   input  logic        req_sample_ok,
   input  logic        req_angle_valid,
   input  logic [31:0] req_mech_angle,
   input  logic        req_core_ok,
   input  logic        req_duty_commit_ok,
   input  logic        req_pwm_enable_ok,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_run_state,
   output logic [6:0]  rsp_fault_bits,
   output logic        rsp_pwm_enabled,
   output logic        rsp_emergency_stop,
   output logic        rsp_calibration_begin,
   output logic        rsp_core_reset,
   output logic [31:0] rsp_electrical_angle,
   output logic        rsp_angle_updated,
   // register port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

`include "motor_drive_lifecycle_supervisor_defines.svh"

   // register file
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pole_pairs         <= POLE_PAIRS_RST;
         cfg_ff.direction_inverted <= 1'b0;
         cfg_ff.electrical_zero    <= '0;
         cfg_ff.calibration_limit  <= CAL_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_POLE_PAIRS: cfg_ff.pole_pairs         <= csr_wdata[7:0];
            CSR_DIR_INV:    cfg_ff.direction_inverted <= csr_wdata[0];
            CSR_ELEC_ZERO:  cfg_ff.electrical_zero    <= csr_wdata;
            CSR_CAL_LIMIT:  cfg_ff.calibration_limit  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // pipeline control
   logic     in_valid_ff;
   item_type item_ff;
   logic     out_valid_ff;
   logic     advance;

   // advance the input word into the result register when that slot is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // input payload: capture on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.command        <= cmd_type'(req_command);
         item_ff.calib_status   <= req_calib_status;
         item_ff.sample_ok      <= req_sample_ok;
         item_ff.angle_valid    <= req_angle_valid;
         item_ff.mech_angle     <= req_mech_angle;
         item_ff.core_ok        <= req_core_ok;
         item_ff.duty_commit_ok <= req_duty_commit_ok;
         item_ff.pwm_enable_ok  <= req_pwm_enable_ok;
      end
   end

   // lifecycle state
   ctl_type               ctl_ff;
   ctl_type               ctl_in;
   logic [TICK_WIDTH-1:0] ticks_ff;
   logic [TICK_WIDTH-1:0] ticks_in;
   logic [31:0]           angle_ff;
   logic [31:0]           angle_in;
   pulse_type             pulses_in;

   mdls_step #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_step (
      .cfg       (cfg_ff),
      .item      (item_ff),
      .ctl_cur   (ctl_ff),
      .ticks_cur (ticks_ff),
      .angle_cur (angle_ff),
      .ctl_nxt   (ctl_in),
      .ticks_nxt (ticks_in),
      .angle_nxt (angle_in),
      .pulses    (pulses_in)
   );

   // commit the tick's state only when its word moves to the result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.life_state  <= LIFE_IDLE;
         ctl_ff.fault_flags <= '0;
         ctl_ff.power_on    <= 1'b0;
         ticks_ff           <= '0;
         angle_ff           <= '0;
      end else if (advance) begin
         ctl_ff   <= ctl_in;
         ticks_ff <= ticks_in;
         angle_ff <= angle_in;
      end
   end

   // result register
   pulse_type pulses_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pulses_ff <= pulses_in;
      end
   end

   // state registers double as the result payload of the last tick
   assign rsp_valid             = out_valid_ff;
   assign rsp_run_state         = ctl_ff.life_state;
   assign rsp_fault_bits        = ctl_ff.fault_flags;
   assign rsp_pwm_enabled       = ctl_ff.power_on;
   assign rsp_electrical_angle  = angle_ff;
   assign rsp_emergency_stop    = pulses_ff.emergency_stop;
   assign rsp_calibration_begin = pulses_ff.calibration_begin;
   assign rsp_core_reset        = pulses_ff.core_reset;
   assign rsp_angle_updated     = pulses_ff.angle_updated;

   // checks
   `MDLS_ASSERT_IMP(a_pwm_only_running, clock, reset, 1'b1,
      ctl_ff.power_on == (ctl_ff.life_state == LIFE_RUN))
   `MDLS_ASSERT_IMP(a_begin_leaves_idle, clock, reset,
      rsp_valid && rsp_calibration_begin, rsp_run_state != LIFE_IDLE)
   `MDLS_ASSERT_IMP(a_core_reset_outcome, clock, reset, rsp_valid && rsp_core_reset,
      rsp_run_state == LIFE_RUN || rsp_run_state == LIFE_FAULT)
   `MDLS_ASSERT_NXT(a_fault_entry_stops, clock, reset,
      advance && ctl_ff.life_state != LIFE_FAULT && ctl_in.life_state == LIFE_FAULT,
      rsp_emergency_stop && !rsp_pwm_enabled)

endmodule
